FILE: rtl/pov_pkg.sv
// shared constants, op codes and controller/datapath command types for the
// pov rotor segment sequencer; no dependencies
`default_nettype none
package pov_pkg;

  localparam int MAX_LOG_SEGMENTS = 9;
  localparam int MAX_LEDS         = 64;
  localparam int MAX_COLOR_BITS   = 4;
  localparam int FULL_RES_LOG     = 9;

  localparam int SEG_W   = MAX_LOG_SEGMENTS;
  localparam int LED_W   = 6;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = MAX_COLOR_BITS;
  localparam int ADDR_W  = SEG_W + LED_W;
  localparam int CLR_W   = ADDR_W + 1;
  localparam int RGB_W   = 24;
  localparam int TICK_W  = 32;
  localparam int CFGI_W  = 3;
  localparam int CFGD_W  = 32;

  localparam logic [RGB_W-1:0] COLOR_RED  = 24'hFF0000;
  localparam logic [RGB_W-1:0] COLOR_BLUE = 24'h0000FF;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_HALL    = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_PALETTE = 2'd3
  } op_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_LOG_SEGMENTS = 3'd0,
    CFG_COLOR_DEPTH  = 3'd1,
    CFG_TDC_SEGMENT  = 3'd2,
    CFG_LED_COUNT    = 3'd3,
    CFG_TIMEOUT      = 3'd4,
    CFG_MIN_REVS     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic clr;    // clear one store entry
    logic exec;   // input beat taken
    logic rd;     // read store at current led
    logic load;   // load result register
    logic next;   // advance led counter
  } pov_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic emit;
    logic led_last;
    logic out_taken;
  } pov_stat_t;

endpackage
`default_nettype wire

FILE: rtl/pov_if.sv
// channel interfaces: input items, result items and configuration writes
// depends on pov_pkg
`default_nettype none
interface pov_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic                     hall_level;
  logic [pov_pkg::SEG_W-1:0] segment_sel;
  logic [pov_pkg::LED_W-1:0] led_sel;
  logic [pov_pkg::IDX_W-1:0] index_value;
  logic [pov_pkg::RGB_W-1:0] rgb_value;
  modport source (output valid, op, hall_level, segment_sel, led_sel, index_value,
                  rgb_value, input ready);
  modport sink   (input valid, op, hall_level, segment_sel, led_sel, index_value,
                  rgb_value, output ready);
endinterface

interface pov_out_if;
  logic                      valid;
  logic                      ready;
  logic [pov_pkg::LED_W-1:0]  led_index;
  logic [pov_pkg::RGB_W-1:0]  led_color;
  logic                      frame_last;
  logic                      frame_kind;
  logic [pov_pkg::SEG_W-1:0]  shown_segment;
  logic                      blank_after;
  logic [pov_pkg::TICK_W-1:0] rotation_period;
  modport source (output valid, led_index, led_color, frame_last, frame_kind,
                  shown_segment, blank_after, rotation_period, input ready);
  modport sink   (input valid, led_index, led_color, frame_last, frame_kind,
                  shown_segment, blank_after, rotation_period, output ready);
endinterface

interface pov_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pov_pkg::CFGI_W-1:0] index;
  logic [pov_pkg::CFGD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pov_ctrl.sv
// sequencing state machine: store clearing pass, item intake, per-led frame
// readout; depends on pov_pkg
`default_nettype none
module pov_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  pov_pkg::pov_stat_t  stat,
  output pov_pkg::pov_cmd_t   cmd
);
  import pov_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD, S_SEND
  } state_t;

  state_t state_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.clr  = (state_r == S_CLEAR);
    cmd.exec = in_ready && in_valid;
    cmd.rd   = (state_r == S_READ);
    cmd.load = (state_r == S_LOAD);
    cmd.next = (state_r == S_SEND) && stat.out_taken && !stat.led_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      case (state_r)
        S_CLEAR: if (stat.clr_last) state_r <= S_IDLE;
        S_IDLE:  if (in_valid && stat.emit) state_r <= S_READ;
        S_READ:  state_r <= S_LOAD;
        S_LOAD:  state_r <= S_SEND;
        S_SEND: begin
          if (stat.out_taken) state_r <= stat.led_last ? S_IDLE : S_READ;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pov_dp.sv
// datapath: config registers, rotation timing, pixel store, palette and the
// result register; depends on pov_pkg and the channel interfaces
`default_nettype none
module pov_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  pov_in_if.sink              in_ch,
  pov_out_if.source           out_ch,
  pov_cfg_if.sink             cfg_ch,
  input  pov_pkg::pov_cmd_t   cmd,
  output pov_pkg::pov_stat_t  stat
);
  import pov_pkg::*;

  // configuration
  logic [3:0]        log_seg_r;
  logic [1:0]        cdepth_r;
  logic [SEG_W-1:0]  tdc_r;
  logic [CNT_W-1:0]  leds_r;
  logic [TICK_W-1:0] timeout_r;
  logic [7:0]        min_revs_r;

  // timing state
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [7:0]        good_r, good_nxt;
  logic              active_r, active_nxt;
  logic [TICK_W-1:0] seg_period_r, seg_period_nxt;
  logic [TICK_W-1:0] countdown_r, countdown_nxt;
  logic              running_r, running_nxt;
  logic [SEG_W-1:0]  ptr_r, ptr_nxt;
  logic [TICK_W-1:0] period_r, period_nxt;
  logic [SEG_W-1:0]  tdc_lat_r, tdc_lat_nxt;

  // frame context
  logic              kind_r, kind_nxt;
  logic [SEG_W-1:0]  fseg_r, fseg_nxt;
  logic              hall_r;
  logic [LED_W-1:0]  led_r;
  logic [CLR_W-1:0]  clr_r;

  logic [IDX_W-1:0]  store [2**ADDR_W];
  logic [RGB_W-1:0]  pal_r [2**IDX_W];
  logic [IDX_W-1:0]  rd_r;

  logic              ovalid_r;
  logic [LED_W-1:0]  oidx_r;
  logic [RGB_W-1:0]  ocolor_r;
  logic              olast_r, okind_r, oblank_r;
  logic [SEG_W-1:0]  oseg_r;
  logic [TICK_W-1:0] operiod_r;

  logic [3:0]        eff_log;
  logic [SEG_W-1:0]  seg_mask;
  logic [IDX_W-1:0]  cmask;
  logic [CNT_W-1:0]  eff_leds;
  logic [TICK_W-1:0] tick1, cd1, sp;
  logic [7:0]        good_inc;
  logic [SEG_W-1:0]  ptr1, tdc_m;
  logic              tmo, emit;
  logic              led_last;
  logic [RGB_W-1:0]  color;

  always_comb begin
    eff_log  = (log_seg_r == 4'd0) ? 4'd1 :
               (log_seg_r > 4'(MAX_LOG_SEGMENTS)) ? 4'(MAX_LOG_SEGMENTS) : log_seg_r;
    seg_mask = SEG_W'((10'd1 << eff_log) - 10'd1);
    case (cdepth_r)
      2'd0:    cmask = IDX_W'(1);
      2'd1:    cmask = IDX_W'(3);
      default: cmask = IDX_W'(15);
    endcase
    eff_leds = (leds_r == '0) ? CNT_W'(1) :
               (leds_r > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : leds_r;
    led_last = ({1'b0, led_r} + CNT_W'(1)) == eff_leds;
  end

  // item decode and timing update
  always_comb begin
    elapsed_nxt    = elapsed_r;
    good_nxt       = good_r;
    active_nxt     = active_r;
    seg_period_nxt = seg_period_r;
    countdown_nxt  = countdown_r;
    running_nxt    = running_r;
    ptr_nxt        = ptr_r;
    period_nxt     = period_r;
    tdc_lat_nxt    = tdc_lat_r;
    kind_nxt       = kind_r;
    fseg_nxt       = fseg_r;
    emit           = 1'b0;
    tick1          = elapsed_r + TICK_W'(1);
    tmo            = tick1 >= timeout_r;
    cd1            = (countdown_r != '0) ? countdown_r - TICK_W'(1) : countdown_r;
    ptr1           = (ptr_r + SEG_W'(1)) & seg_mask;
    sp             = elapsed_r >> eff_log;
    good_inc       = (good_r != 8'hFF) ? good_r + 8'd1 : good_r;
    tdc_m          = tdc_r & seg_mask;
    case (op_t'(in_ch.op))
      OP_TICK: begin
        if (tmo) begin
          elapsed_nxt   = '0;
          running_nxt   = 1'b0;
          countdown_nxt = '0;
          good_nxt      = '0;
          active_nxt    = 1'b0;
          kind_nxt      = 1'b1;
          fseg_nxt      = '0;
          emit          = 1'b1;
        end else begin
          elapsed_nxt = tick1;
          if (running_r) begin
            countdown_nxt = cd1;
            if (cd1 == '0) begin
              emit     = 1'b1;
              kind_nxt = 1'b0;
              fseg_nxt = ptr_r;
              ptr_nxt  = ptr1;
              if (ptr1 == tdc_lat_r) running_nxt = 1'b0;
              else countdown_nxt = seg_period_r;
            end
          end
        end
      end
      OP_HALL: begin
        elapsed_nxt = '0;
        if (!active_r) begin
          good_nxt = good_inc;
          if (good_inc >= min_revs_r) active_nxt = 1'b1;
        end else begin
          period_nxt     = elapsed_r;
          seg_period_nxt = (sp == '0) ? TICK_W'(1) : sp;
          countdown_nxt  = (sp == '0) ? TICK_W'(1) : sp;
          running_nxt    = 1'b1;
          tdc_lat_nxt    = tdc_m;
          ptr_nxt        = (tdc_m + SEG_W'(1)) & seg_mask;
          kind_nxt       = 1'b0;
          fseg_nxt       = tdc_m;
          emit           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_seg_r  <= 4'd1;
      cdepth_r   <= 2'd0;
      tdc_r      <= '0;
      leds_r     <= CNT_W'(64);
      timeout_r  <= TICK_W'(4800000);
      min_revs_r <= 8'd3;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_LOG_SEGMENTS: log_seg_r  <= cfg_ch.data[3:0];
        CFG_COLOR_DEPTH:  cdepth_r   <= cfg_ch.data[1:0];
        CFG_TDC_SEGMENT:  tdc_r      <= cfg_ch.data[SEG_W-1:0];
        CFG_LED_COUNT:    leds_r     <= cfg_ch.data[CNT_W-1:0];
        CFG_TIMEOUT:      timeout_r  <= cfg_ch.data;
        CFG_MIN_REVS:     min_revs_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      good_r       <= '0;
      active_r     <= 1'b0;
      seg_period_r <= '0;
      countdown_r  <= '0;
      running_r    <= 1'b0;
      ptr_r        <= '0;
      period_r     <= '0;
      tdc_lat_r    <= '0;
      clr_r        <= '0;
      led_r        <= '0;
      ovalid_r     <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + CLR_W'(1);
      if (cmd.exec) begin
        elapsed_r    <= elapsed_nxt;
        good_r       <= good_nxt;
        active_r     <= active_nxt;
        seg_period_r <= seg_period_nxt;
        countdown_r  <= countdown_nxt;
        running_r    <= running_nxt;
        ptr_r        <= ptr_nxt;
        period_r     <= period_nxt;
        tdc_lat_r    <= tdc_lat_nxt;
        led_r        <= '0;
      end else if (cmd.next) begin
        led_r <= led_r + LED_W'(1);
      end
      if (cmd.load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  // frame context, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kind_r <= kind_nxt;
      fseg_r <= fseg_nxt;
      hall_r <= in_ch.hall_level;
    end
  end

  // pixel store: one write port shared by the clearing pass, one read port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      store[clr_r[ADDR_W-1:0]] <= '0;
    end else if (cmd.exec && op_t'(in_ch.op) == OP_PIXEL) begin
      store[{in_ch.segment_sel, in_ch.led_sel}] <= in_ch.index_value & cmask;
    end
    if (cmd.rd) rd_r <= store[{fseg_r, led_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2**IDX_W; i++) pal_r[i] <= '0;
    end else if (cmd.exec && op_t'(in_ch.op) == OP_PALETTE) begin
      pal_r[in_ch.index_value] <= in_ch.rgb_value;
    end
  end

  always_comb begin
    if (kind_r) color = led_last ? (hall_r ? COLOR_BLUE : COLOR_RED) : '0;
    else        color = pal_r[rd_r & cmask];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oidx_r    <= led_r;
      ocolor_r  <= color;
      olast_r   <= led_last;
      okind_r   <= kind_r;
      oseg_r    <= fseg_r;
      oblank_r  <= !kind_r && (eff_log < 4'(FULL_RES_LOG));
      operiod_r <= period_r;
    end
  end

  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = ovalid_r;
  assign out_ch.led_index      = oidx_r;
  assign out_ch.led_color      = ocolor_r;
  assign out_ch.frame_last     = olast_r;
  assign out_ch.frame_kind     = okind_r;
  assign out_ch.shown_segment  = oseg_r;
  assign out_ch.blank_after    = oblank_r;
  assign out_ch.rotation_period = operiod_r;

  always_comb begin
    stat           = '0;
    stat.clr_last  = (clr_r[ADDR_W-1:0] == '1);
    stat.emit      = emit;
    stat.led_last  = led_last;
    stat.out_taken = ovalid_r && out_ch.ready;
  end
endmodule
`default_nettype wire

FILE: rtl/pov_rotation_segment_sequencer_unit.sv
// top level of the pov rotor segment sequencer: controller plus datapath
// depends on pov_pkg, pov_if, pov_ctrl and pov_dp
//
// in_ch carries one item per beat: ticks, hall edges, pixel and palette writes.
// out_ch carries one beat per led of a frame; a frame is led_count beats,
// frame_last marks its final beat. cfg_ch writes a register by index and is
// always ready.
// for an item that causes a frame, each led goes through a store read, a
// palette lookup into the result register and the handover, in that order;
// the pixel store has a single read port.
// the input is not ready while a frame is being sent; a stalled receiver
// simply holds the result register and the led sequencer waits.
// after reset the pixel store is cleared one entry a cycle, during which no
// item is accepted; config writes are taken throughout.
// registers, timers, palette and qualification return to reset values.
`default_nettype none
module pov_rotation_segment_sequencer_unit (
  input  wire        clk,
  input  wire        rst_n,
  pov_in_if.sink     in_ch,
  pov_out_if.source  out_ch,
  pov_cfg_if.sink    cfg_ch
);
  import pov_pkg::*;

  pov_cmd_t  cmd;
  pov_stat_t stat;

  pov_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pov_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

  // no intake while a beat is waiting
  a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while result pending");

  // a frame-causing item blocks the input next cycle
  a_frame_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && stat.emit) |=> !in_ch.ready)
    else $error("frame did not start");

  // the clearing pass never overlaps item handling
  a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !cmd.exec && !out_ch.valid)
    else $error("item handled during store clear");
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for the pov rotor segment sequencer: random and directed items,
// a self-contained predictor and an in-order result check; uses pov_pkg and pov_if
`default_nettype none
module tb;
  import pov_pkg::*;

  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int PAL_DEPTH   = 1 << IDX_W;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD   = 3000;

  typedef struct packed {
    op_t               op;
    logic              hall;
    logic [SEG_W-1:0]  seg;
    logic [LED_W-1:0]  led;
    logic [IDX_W-1:0]  idx;
    logic [RGB_W-1:0]  rgb;
  } rotor_item_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_index;
    logic [RGB_W-1:0]  led_color;
    logic              frame_last;
    logic              frame_kind;
    logic [SEG_W-1:0]  shown_segment;
    logic              blank_after;
    logic [TICK_W-1:0] rotation_period;
  } led_beat_t;

  logic clk;
  logic rst_n;

  pov_in_if  in_ch ();
  pov_out_if out_ch ();
  pov_cfg_if cfg_ch ();

  pov_rotation_segment_sequencer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor registers and state
  logic [3:0]        r_log;
  logic [1:0]        r_depth;
  logic [SEG_W-1:0]  r_tdc;
  logic [6:0]        r_leds;
  logic [TICK_W-1:0] r_timeout;
  logic [7:0]        r_min_revs;

  logic [TICK_W-1:0] elapsed, seg_period, countdown, last_period;
  logic [7:0]        good_revs;
  logic              active, running;
  logic [SEG_W-1:0]  pointer, tdc_held;
  logic [IDX_W-1:0]  pixel_store [STORE_DEPTH];
  logic [RGB_W-1:0]  palette [PAL_DEPTH];

  rotor_item_t pending_items [$];
  led_beat_t   expected_beats [$];

  int  mismatches;
  int  cycles;
  bit  in_taken;
  int  burst_left, gap_left;
  bit  gappy;
  int  hold_left, mode_left;
  bit  hold_req;
  int  stall_mode;
  logic [15:0] stall_pattern;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_log();
    int unsigned l;
    l = 32'(r_log);
    if (l < 1) l = 1;
    if (l > MAX_LOG_SEGMENTS) l = MAX_LOG_SEGMENTS;
    return l;
  endfunction

  function automatic logic [SEG_W-1:0] seg_mask();
    return SEG_W'((1 << eff_log()) - 1);
  endfunction

  function automatic logic [IDX_W-1:0] depth_mask();
    int unsigned c, bits;
    c = (r_depth > 2) ? 2 : 32'(r_depth);
    bits = 1 << c;
    if (bits > MAX_COLOR_BITS) bits = MAX_COLOR_BITS;
    return IDX_W'((1 << bits) - 1);
  endfunction

  function automatic int unsigned eff_leds();
    int unsigned n;
    n = 32'(r_leds);
    if (n < 1) n = 1;
    if (n > MAX_LEDS) n = MAX_LEDS;
    return n;
  endfunction

  task automatic push_segment_frame(input logic [SEG_W-1:0] seg);
    int unsigned n;
    led_beat_t b;
    n = eff_leds();
    for (int unsigned i = 0; i < n; i++) begin
      b.led_index       = LED_W'(i);
      b.led_color       = palette[pixel_store[{seg, LED_W'(i)}] & depth_mask()];
      b.frame_last      = (i + 1 == n);
      b.frame_kind      = 1'b0;
      b.shown_segment   = seg;
      b.blank_after     = (eff_log() < FULL_RES_LOG);
      b.rotation_period = last_period;
      expected_beats.push_back(b);
    end
  endtask

  task automatic push_error_frame(input logic hall);
    int unsigned n;
    led_beat_t b;
    n = eff_leds();
    for (int unsigned i = 0; i < n; i++) begin
      b.led_index       = LED_W'(i);
      b.frame_last      = (i + 1 == n);
      b.led_color       = !b.frame_last ? '0 : (hall ? COLOR_BLUE : COLOR_RED);
      b.frame_kind      = 1'b1;
      b.shown_segment   = '0;
      b.blank_after     = 1'b0;
      b.rotation_period = last_period;
      expected_beats.push_back(b);
    end
  endtask

  task automatic predict_item(input rotor_item_t it);
    logic [SEG_W-1:0] shown;
    case (it.op)
      OP_TICK: begin
        elapsed = elapsed + 32'd1;
        if (elapsed >= r_timeout) begin
          // timeout beats any segment expiry on the same tick
          elapsed = '0;
          running = 1'b0;
          countdown = '0;
          good_revs = '0;
          active = 1'b0;
          push_error_frame(it.hall);
        end else if (running) begin
          if (countdown > 0) countdown = countdown - 32'd1;
          if (countdown == 0) begin
            shown = pointer;
            push_segment_frame(shown);
            pointer = (shown + 1'b1) & seg_mask();
            if (pointer == tdc_held) running = 1'b0;
            else countdown = seg_period;
          end
        end
      end
      OP_HALL: begin
        if (!active) begin
          elapsed = '0;
          if (good_revs < 8'd255) good_revs = good_revs + 8'd1;
          if (good_revs >= r_min_revs) active = 1'b1;
        end else begin
          last_period = elapsed;
          elapsed = '0;
          seg_period = last_period >> eff_log();
          if (seg_period == 0) seg_period = 32'd1;
          countdown = seg_period;
          running = 1'b1;
          tdc_held = r_tdc & seg_mask();
          pointer = (tdc_held + 1'b1) & seg_mask();
          push_segment_frame(tdc_held);
        end
      end
      OP_PIXEL: pixel_store[{it.seg, it.led}] = it.idx & depth_mask();
      OP_PALETTE: palette[it.idx] = it.rgb;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    $display("tb: mismatch %s expected %0h got %0h at %0t", what, want, got, $realtime);
  endtask

  // monitor and predictor, sampled at the rising edge
  always @(posedge clk) begin
    led_beat_t w;
    rotor_item_t it;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, {26'd0, out_ch.led_index});
      end else begin
        w = expected_beats.pop_front();
        if (out_ch.led_index != w.led_index)
          report_mismatch("led_index", 32'(w.led_index), 32'(out_ch.led_index));
        if (out_ch.led_color != w.led_color)
          report_mismatch("led_color", 32'(w.led_color), 32'(out_ch.led_color));
        if (out_ch.frame_last != w.frame_last)
          report_mismatch("frame_last", 32'(w.frame_last), 32'(out_ch.frame_last));
        if (out_ch.frame_kind != w.frame_kind)
          report_mismatch("frame_kind", 32'(w.frame_kind), 32'(out_ch.frame_kind));
        if (out_ch.shown_segment != w.shown_segment)
          report_mismatch("shown_segment", 32'(w.shown_segment),
                          32'(out_ch.shown_segment));
        if (out_ch.blank_after != w.blank_after)
          report_mismatch("blank_after", 32'(w.blank_after), 32'(out_ch.blank_after));
        if (out_ch.rotation_period != w.rotation_period)
          report_mismatch("rotation_period", w.rotation_period, out_ch.rotation_period);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.op   = op_t'(in_ch.op);
      it.hall = in_ch.hall_level;
      it.seg  = in_ch.segment_sel;
      it.led  = in_ch.led_sel;
      it.idx  = in_ch.index_value;
      it.rgb  = in_ch.rgb_value;
      predict_item(it);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // sender: bursts with gaps, a beat once offered stays until taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) void'(pending_items.pop_front());
      if (!(in_ch.valid && !in_taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid       <= 1'b1;
          in_ch.op          <= pending_items[0].op;
          in_ch.hall_level  <= pending_items[0].hall;
          in_ch.segment_sel <= pending_items[0].seg;
          in_ch.led_sel     <= pending_items[0].led;
          in_ch.index_value <= pending_items[0].idx;
          in_ch.rgb_value   <= pending_items[0].rgb;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0) gappy = !gappy;
            gap_left = gappy ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, clean stretches and one long hold
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          mode_left = $urandom_range(20, 200);
          stall_mode = $urandom_range(0, 2);
          stall_pattern = 16'($urandom);
        end
        mode_left--;
        out_ch.ready <= (stall_mode == 0) ? 1'b1 : stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  function automatic rotor_item_t make_item(input op_t op, input logic hall,
                                            input logic [SEG_W-1:0] seg,
                                            input logic [LED_W-1:0] led,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [RGB_W-1:0] rgb);
    rotor_item_t it;
    it.op = op; it.hall = hall; it.seg = seg; it.led = led; it.idx = idx; it.rgb = rgb;
    return it;
  endfunction

  function automatic rotor_item_t rand_item(input op_t op);
    return make_item(op, 1'($urandom_range(0, 1)), SEG_W'($urandom_range(0, 511)),
                     LED_W'($urandom_range(0, 63)), IDX_W'($urandom_range(0, 15)),
                     RGB_W'($urandom));
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_beats.size() != 0) @(posedge clk);
    // a last tick may still be in flight with nothing to show for it
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFGD_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_LOG_SEGMENTS: r_log      = data[3:0];
      CFG_COLOR_DEPTH:  r_depth    = data[1:0];
      CFG_TDC_SEGMENT:  r_tdc      = data[SEG_W-1:0];
      CFG_LED_COUNT:    r_leds     = data[6:0];
      CFG_TIMEOUT:      r_timeout  = data;
      CFG_MIN_REVS:     r_min_revs = data[7:0];
      default: ;
    endcase
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) pending_items.push_back(rand_item(OP_TICK));
  endtask

  initial begin
    logic [3:0]  lg;
    logic [6:0]  leds;
    logic [31:0] tmo;
    logic [7:0]  revs;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.op = OP_TICK; in_ch.hall_level = 1'b0;
    in_ch.segment_sel = '0; in_ch.led_sel = '0; in_ch.index_value = '0;
    in_ch.rgb_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_LOG_SEGMENTS; cfg_ch.data = '0;
    mismatches = 0; cycles = 0; in_taken = 1'b0;
    burst_left = 4; gap_left = 0; gappy = 1'b0;
    hold_left = 0; hold_req = 1'b0; mode_left = 0; stall_mode = 0; stall_pattern = '1;
    r_log = 4'd1; r_depth = 2'd0; r_tdc = '0; r_leds = 7'd64;
    r_timeout = 32'd4800000; r_min_revs = 8'd3;
    elapsed = '0; seg_period = '0; countdown = '0; last_period = '0;
    good_revs = '0; active = 1'b0; running = 1'b0; pointer = '0; tdc_held = '0;
    foreach (pixel_store[i]) pixel_store[i] = '0;
    foreach (palette[i]) palette[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: two segments, 64 leds, one bit per pixel
    pending_items.push_back(make_item(OP_PALETTE, 1'b0, 9'd0, 6'd0, 4'd0, 24'hFFFFFF));
    pending_items.push_back(make_item(OP_PALETTE, 1'b0, 9'd0, 6'd0, 4'd1, 24'hA5A5A5));
    pending_items.push_back(make_item(OP_PALETTE, 1'b0, 9'd0, 6'd0, 4'd15, 24'h000000));
    pending_items.push_back(make_item(OP_PIXEL, 1'b0, 9'd0, 6'd0, 4'd15, 24'd0));
    pending_items.push_back(make_item(OP_PIXEL, 1'b0, 9'd511, 6'd63, 4'd1, 24'd0));
    pending_items.push_back(make_item(OP_PIXEL, 1'b0, 9'd1, 6'd63, 4'd1, 24'd0));
    pending_items.push_back(make_item(OP_HALL, 1'b1, 9'd0, 6'd0, 4'd0, 24'd0));
    pending_items.push_back(make_item(OP_HALL, 1'b0, 9'd0, 6'd0, 4'd0, 24'd0));
    pending_items.push_back(make_item(OP_HALL, 1'b1, 9'd0, 6'd0, 4'd0, 24'd0));
    queue_ticks(4);
    pending_items.push_back(make_item(OP_HALL, 1'b0, 9'd0, 6'd0, 4'd0, 24'd0));
    queue_ticks(3);
    wait_idle();

    // timeout landing on a segment expiry, then a repeated timeout
    write_reg(CFG_LOG_SEGMENTS, 32'd3);
    write_reg(CFG_TIMEOUT, 32'd3);
    write_reg(CFG_LED_COUNT, 32'd2);
    write_reg(CFG_MIN_REVS, 32'd1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    pending_items.push_back(make_item(OP_HALL, 1'b0, 9'd0, 6'd0, 4'd0, 24'd0));
    pending_items.push_back(make_item(OP_HALL, 1'b1, 9'd0, 6'd0, 4'd0, 24'd0));
    queue_ticks(6);

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      case (p)
        0: begin lg = 4'd9;  leds = 7'd64;  tmo = 32'hFFFFFFFF; revs = 8'd2; end
        1: begin lg = 4'd15; leds = 7'd127; tmo = 32'd0;        revs = 8'd0; end
        2: begin lg = 4'd0;  leds = 7'd0;   tmo = 32'd1;        revs = 8'd255; end
        3: begin lg = 4'd1;  leds = 7'd1;   tmo = 32'd2;        revs = 8'd1; end
        default: begin
          lg = 4'($urandom_range(1, 4));
          leds = 7'($urandom_range(1, 8));
          tmo = $urandom_range(3, 60);
          revs = 8'($urandom_range(1, 3));
        end
      endcase
      write_reg(CFG_LOG_SEGMENTS, 32'(lg));
      write_reg(CFG_COLOR_DEPTH, 32'(p % 4));
      write_reg(CFG_TDC_SEGMENT, (p == 0) ? 32'd511 : $urandom_range(0, 511));
      write_reg(CFG_LED_COUNT, 32'(leds));
      write_reg(CFG_TIMEOUT, tmo);
      write_reg(CFG_MIN_REVS, 32'(revs));
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
      // receiver holds off while frames pile up behind it
      if (p == 4) hold_req = 1'b1;
      repeat (4) pending_items.push_back(rand_item($urandom_range(0, 1) ? OP_PIXEL : OP_PALETTE));
      repeat ($urandom_range(3, 5)) begin
        queue_ticks($urandom_range(0, 10));
        pending_items.push_back(rand_item(OP_HALL));
      end
      repeat (3) pending_items.push_back(rand_item(op_t'($urandom_range(0, 3))));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/pov_pkg.sv
rtl/pov_if.sv
rtl/pov_ctrl.sv
rtl/pov_dp.sv
rtl/pov_rotation_segment_sequencer_unit.sv
tb/sv/tb.sv
